// ----- rtl/core/dns_name_label_codec_assert.svh -----
// ----------------------------------------------------------------------------
// DNS name label codec assertion macros
// Shared concurrent assertion forms for the codec RTL.
// ----------------------------------------------------------------------------
`ifndef DNS_NAME_LABEL_CODEC_ASSERT_SVH
`define DNS_NAME_LABEL_CODEC_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define DNC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dnc: implication check failed");

// Next-cycle implication.
`define DNC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dnc: next-cycle check failed");

`endif

// ----- rtl/core/dnc_pkg.sv -----
// ----------------------------------------------------------------------------
// DNS name label codec package
// Shared types and constants of the codec.
// ----------------------------------------------------------------------------
package dnc_pkg;

   localparam int NAME_BYTES_DEF       = 256;
   localparam int MAX_LABEL_DEF        = 63;
   localparam int WIRE_LABEL_CLAMP_DEF = 64;

   localparam logic [7:0] DOT_CHAR  = 8'h2E;
   localparam logic [7:0] NUL_CHAR  = 8'h00;

   // Direction register encoding
   localparam logic DIR_TEXT_TO_WIRE = 1'b0;
   localparam logic DIR_WIRE_TO_TEXT = 1'b1;

   // CSR map: register index taken from paddr[2]
   localparam int          CSR_ADDR_W    = 3;
   localparam logic        CSR_DIRECTION = 1'b0;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] write_addr;
      logic [7:0] write_byte;
      logic       name_done;
      logic       error;
   } result_type;

   // Results produced by one request: r1 is only used when r0 is
   typedef struct packed {
      logic       v0;
      logic       v1;
      result_type r0;
      result_type r1;
   } emit_type;

endpackage

// ----- rtl/core/dnc_csr.sv -----
// ----------------------------------------------------------------------------
// DNS name label codec CSR block
// APB-style direction register; a write also restarts the current name.
// ----------------------------------------------------------------------------
module dnc_csr import dnc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output logic                  direction,
   output logic                  restart
);

   logic direction_ff;
   logic direction_in;
   logic wr_hit;

   assign csr_pready   = 1'b1;
   assign wr_hit       = csr_psel & csr_penable & csr_pwrite & csr_pready
                         & (csr_paddr[2] == CSR_DIRECTION);
   assign direction_in = wr_hit ? csr_pwdata[0] : direction_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_TEXT_TO_WIRE;
      end else begin
         direction_ff <= direction_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_DIRECTION) ? {31'd0, direction_ff} : 32'd0;
   assign direction  = direction_ff;
   assign restart    = wr_hit;

endmodule

// ----- rtl/core/dnc_engine.sv -----
// ----------------------------------------------------------------------------
// DNS name label codec engine
// Input register, per-name state and the single-pass conversion logic.
// ----------------------------------------------------------------------------
module dnc_engine import dnc_pkg::*; #(
   parameter int NAME_BYTES       = NAME_BYTES_DEF,
   parameter int MAX_LABEL        = MAX_LABEL_DEF,
   parameter int WIRE_LABEL_CLAMP = WIRE_LABEL_CLAMP_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       direction,
   input  logic       restart,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       room,
   output emit_type   emit
);

   localparam int         AddrSpan = (NAME_BYTES < 256) ? NAME_BYTES : 256;
   localparam logic [8:0] Span9    = 9'(AddrSpan);
   localparam logic [7:0] MaxLab8  = 8'(MAX_LABEL);
   localparam logic [7:0] Clamp8   = 8'(WIRE_LABEL_CLAMP);

   `include "dns_name_label_codec_assert.svh"

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff,  in_byte_in;
   logic [8:0] byte_index_ff, byte_index_in;
   logic [8:0] label_slot_ff, label_slot_in;
   logic [7:0] label_count_ff, label_count_in;
   logic       at_start_ff, at_start_in;
   logic       error_ff, error_in;

   logic       accept, fire;
   logic [7:0] b;
   logic [8:0] bi_inc, bi_dec;
   logic       text_full, wire_in_range;

   assign fire      = in_valid_ff & room;
   assign req_stall = in_valid_ff & ~room;
   assign accept    = req_valid & ~req_stall;

   assign in_valid_in = accept | (in_valid_ff & ~fire);
   assign in_byte_in  = accept ? req_in_byte : in_byte_ff;

   assign b             = in_byte_ff;
   assign bi_inc        = byte_index_ff + 9'd1;
   assign bi_dec        = byte_index_ff - 9'd1;
   // text mode keeps room for the closing zero
   assign text_full     = ({1'b0, byte_index_ff} + 10'd2) >= {1'b0, Span9};
   assign wire_in_range = (byte_index_ff < Span9) && (byte_index_ff != 9'd0);

   always_comb begin
      byte_index_in  = byte_index_ff;
      label_slot_in  = label_slot_ff;
      label_count_in = label_count_ff;
      at_start_in    = at_start_ff;
      error_in       = error_ff;
      emit           = '0;
      emit.r0.error  = error_ff;
      emit.r1.error  = error_ff;

      if (fire) begin
         if (direction == DIR_TEXT_TO_WIRE) begin
            if (b != DOT_CHAR && b != NUL_CHAR) begin
               if (label_count_ff >= MaxLab8 || text_full) begin
                  error_in = 1'b1;
               end else begin
                  emit.v0            = 1'b1;
                  emit.r0.write_addr = bi_inc[7:0];
                  emit.r0.write_byte = b;
                  byte_index_in      = bi_inc;
                  label_count_in     = label_count_ff + 8'd1;
                  at_start_in        = 1'b0;
               end
            end else if (b == DOT_CHAR) begin
               if (text_full) begin
                  error_in = 1'b1;
               end else begin
                  emit.v0            = 1'b1;
                  emit.r0.write_addr = label_slot_ff[7:0];
                  emit.r0.write_byte = label_count_ff;
                  label_slot_in      = bi_inc;
                  byte_index_in      = bi_inc;
                  label_count_in     = 8'd0;
                  at_start_in        = 1'b0;
               end
            end else begin
               emit.v0            = 1'b1;
               emit.r0.write_addr = label_slot_ff[7:0];
               if (label_count_ff == 8'd0) begin
                  emit.r0.write_byte = NUL_CHAR;
                  emit.r0.name_done  = 1'b1;
               end else begin
                  emit.r0.write_byte = label_count_ff;
                  emit.v1            = 1'b1;
                  emit.r1.write_addr = bi_inc[7:0];
                  emit.r1.write_byte = NUL_CHAR;
                  emit.r1.name_done  = 1'b1;
               end
               byte_index_in  = 9'd0;
               label_slot_in  = 9'd0;
               label_count_in = 8'd0;
               at_start_in    = 1'b1;
               error_in       = 1'b0;
            end
         end else begin
            if (label_count_ff != 8'd0) begin
               label_count_in = label_count_ff - 8'd1;
               if (wire_in_range) begin
                  emit.v0            = 1'b1;
                  emit.r0.write_addr = bi_dec[7:0];
                  emit.r0.write_byte = b;
               end else begin
                  error_in = 1'b1;
               end
               byte_index_in = (byte_index_ff < Span9) ? bi_inc : byte_index_ff;
               at_start_in   = 1'b0;
            end else if (b == NUL_CHAR) begin
               emit.v0            = 1'b1;
               // byte_index never passes the span, so index minus one fits
               emit.r0.write_addr = (at_start_ff || byte_index_ff == 9'd0) ? 8'd0
                                                                           : bi_dec[7:0];
               emit.r0.write_byte = NUL_CHAR;
               emit.r0.name_done  = 1'b1;
               byte_index_in      = 9'd0;
               label_slot_in      = 9'd0;
               label_count_in     = 8'd0;
               at_start_in        = 1'b1;
               error_in           = 1'b0;
            end else begin
               error_in       = error_ff | (b > MaxLab8);
               label_count_in = (b > Clamp8) ? Clamp8 : b;
               emit.r0.error  = error_ff | (b > MaxLab8);
               if (!at_start_ff) begin
                  if (wire_in_range) begin
                     emit.v0            = 1'b1;
                     emit.r0.write_addr = bi_dec[7:0];
                     emit.r0.write_byte = DOT_CHAR;
                  end else begin
                     error_in = 1'b1;
                  end
               end
               byte_index_in = (byte_index_ff < Span9) ? bi_inc : byte_index_ff;
               at_start_in   = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         byte_index_ff  <= 9'd0;
         label_slot_ff  <= 9'd0;
         label_count_ff <= 8'd0;
         at_start_ff    <= 1'b1;
         error_ff       <= 1'b0;
      end else if (restart) begin
         in_valid_ff    <= in_valid_in;
         byte_index_ff  <= 9'd0;
         label_slot_ff  <= 9'd0;
         label_count_ff <= 8'd0;
         at_start_ff    <= 1'b1;
         error_ff       <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         byte_index_ff  <= byte_index_in;
         label_slot_ff  <= label_slot_in;
         label_count_ff <= label_count_in;
         at_start_ff    <= at_start_in;
         error_ff       <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   `DNC_ASSERT_IMPL(a_second_after_first, clock, reset, emit.v1,
                    emit.v0 && emit.r1.name_done && !emit.r0.name_done)
   `DNC_ASSERT_NEXT(a_done_restarts, clock, reset, emit.v0 && (emit.r0.name_done
                    || emit.v1) && !restart, at_start_ff && byte_index_ff == 9'd0
                    && !error_ff)
   `DNC_ASSERT_IMPL(a_text_index_bound, clock, reset,
                    direction == DIR_TEXT_TO_WIRE && !at_start_ff,
                    {1'b0, byte_index_ff} < {1'b0, Span9})

endmodule

// ----- rtl/core/dnc_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// DNS name label codec response queue
// Small register queue taking up to two results a cycle, giving out one while rsp_stall is low.
// ----------------------------------------------------------------------------
module dnc_rsp_queue import dnc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  emit_type   emit,
   output logic       room,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp
);

   `include "dns_name_label_codec_assert.svh"

   result_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] head_ff, head_in;
   logic [QUEUE_PTR_W-1:0] tail_ff, tail_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [QUEUE_PTR_W-1:0] tail_next;
   logic [QUEUE_CNT_W-1:0] push_n;
   logic                   pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp       = entry_ff[head_ff];
   assign pop       = rsp_valid & ~rsp_stall;
   // leave space for a two-result request
   assign room      = (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));

   assign push_n    = emit.v1 ? QUEUE_CNT_W'(2) : (emit.v0 ? QUEUE_CNT_W'(1) : '0);
   assign tail_next = tail_ff + QUEUE_PTR_W'(1);
   assign tail_in   = tail_ff + push_n[QUEUE_PTR_W-1:0];
   assign head_in   = pop ? head_ff + QUEUE_PTR_W'(1) : head_ff;
   assign count_in  = count_ff + push_n - (pop ? QUEUE_CNT_W'(1) : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.v0) begin
         entry_ff[tail_ff] <= emit.r0;
      end
      if (emit.v1) begin
         entry_ff[tail_next] <= emit.r1;
      end
   end

   `DNC_ASSERT_IMPL(a_push_has_room, clock, reset, emit.v0,
                    count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2))
   `DNC_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1,
                    count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))

endmodule

// ----- rtl/core/dns_name_label_codec.sv -----
// ----------------------------------------------------------------------------
// DNS name label codec
// Converts domain names between dotted text and length-prefixed wire form.
// ----------------------------------------------------------------------------
// One name byte is taken per request, up to one request per clock. Each
// request is registered and converted in a single pass against the per-name
// counters. Its zero, one or two addressed writes land in a four-entry
// response queue at the next edge. So a response reaches the outputs through
// the request register and a queue entry, and leaves while rsp_stall is low.
// Only a text terminator that closes an open label makes two responses; all
// other bytes make at most one. req_stall rises only while a request is held
// and the response queue has fewer than two free places. With rsp_stall low
// the codec takes one request per cycle. The exception is the second write
// of a terminator: it needs its own turn at the outputs, so a run of short
// names can back the queue up and stall requests. The direction register
// (offset 0) selects text to wire (0) or wire to text (1); writing it
// restarts the name.
// ----------------------------------------------------------------------------
module dns_name_label_codec import dnc_pkg::*; #(
   parameter int NAME_BYTES       = NAME_BYTES_DEF,
   parameter int MAX_LABEL        = MAX_LABEL_DEF,
   parameter int WIRE_LABEL_CLAMP = WIRE_LABEL_CLAMP_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_in_byte,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_write_addr,
   output logic [7:0]            rsp_write_byte,
   output logic                  rsp_name_done,
   output logic                  rsp_error
);

   logic       direction;
   logic       restart;
   logic       room;
   emit_type   emit;
   result_type rsp;

   // Direction register; a write also clears all name state
   dnc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .direction   (direction),
      .restart     (restart)
   );

   // Request register, name counters and conversion logic
   dnc_engine #(
      .NAME_BYTES       (NAME_BYTES),
      .MAX_LABEL        (MAX_LABEL),
      .WIRE_LABEL_CLAMP (WIRE_LABEL_CLAMP)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .direction   (direction),
      .restart     (restart),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .room        (room),
      .emit        (emit)
   );

   // Response queue decouples two-write terminators from rsp_stall
   dnc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_write_addr = rsp.write_addr;
   assign rsp_write_byte = rsp.write_byte;
   assign rsp_name_done  = rsp.name_done;
   assign rsp_error      = rsp.error;

endmodule
